// ===== src/tssg_pkg.sv =====
// ----------------------------------------------------------------------------
// tssg_pkg
// Shared constants, codes and types for the triangle scanline span generator.
// ----------------------------------------------------------------------------
package tssg_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int FRAC_BITS_DEFAULT  = 16;
   localparam int POS_W              = 32;
   localparam int FILL_W             = 32;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_SPAN = 1'b1;

   localparam logic [POS_W-1:0] SLOPE_MAX = 32'h7FFF_FFFF;
   localparam logic [POS_W-1:0] SLOPE_MIN = 32'h8000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SPLIT,
      ST_SLOPE0,
      ST_SLOPE1,
      ST_SPAN
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_UPPER,
      PH_LOWER
   } phase_type;

   typedef enum logic [1:0] {
      SEG_UPPER,
      SEG_LOWER,
      SEG_FLAT_TOP
   } seg_type;

   typedef enum logic [2:0] {
      DIV_SPLIT,
      DIV_UP0,
      DIV_UP1,
      DIV_LO0,
      DIV_LO1,
      DIV_FT0,
      DIV_FT1
   } div_sel_type;

   typedef enum logic [1:0] {
      SPLIT_X2,
      SPLIT_X0,
      SPLIT_DIV
   } split_sel_type;

   typedef struct packed {
      logic          load;
      logic          div_start;
      div_sel_type   div_sel;
      logic          split_wr;
      split_sel_type split_sel;
      logic          slope_wr;
      logic          slope_idx;
      logic          init_upper;
      logic          init_lower;
      logic          emit;
      logic          step_up;
      logic          step_down;
      logic          go_idle;
   } dp_cmd_type;

   typedef struct packed {
      phase_type phase;
      logic      row_at_y1;
      logic      y0_eq_y1;
      logic      y1_eq_y2;
      logic      div_done;
   } dp_sts_type;

endpackage

// ===== src/tssg_if.sv =====
// ----------------------------------------------------------------------------
// tssg_req_if / tssg_rsp_if
// Valid/ready channels carrying request words in and span words out.
// ----------------------------------------------------------------------------
interface tssg_req_if #(
   parameter int COORD_BITS = tssg_pkg::COORD_BITS_DEFAULT
);
   logic                               valid;
   logic                               ready;
   logic                               command;
   logic signed [COORD_BITS-1:0]       vert_a_x;
   logic signed [COORD_BITS-1:0]       vert_a_y;
   logic signed [COORD_BITS-1:0]       vert_b_x;
   logic signed [COORD_BITS-1:0]       vert_b_y;
   logic signed [COORD_BITS-1:0]       vert_c_x;
   logic signed [COORD_BITS-1:0]       vert_c_y;
   logic        [tssg_pkg::FILL_W-1:0] fill_value;

   modport source (
      output valid, command, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
             vert_c_x, vert_c_y, fill_value,
      input  ready
   );

   modport sink (
      input  valid, command, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
             vert_c_x, vert_c_y, fill_value,
      output ready
   );
endinterface

interface tssg_rsp_if #(
   parameter int COORD_BITS = tssg_pkg::COORD_BITS_DEFAULT
);
   logic                               valid;
   logic                               ready;
   logic signed [COORD_BITS-1:0]       row;
   logic signed [COORD_BITS:0]         span_from;
   logic signed [COORD_BITS:0]         span_to;
   logic        [tssg_pkg::FILL_W-1:0] fill_out;
   logic                               last_row;

   modport source (
      output valid, row, span_from, span_to, fill_out, last_row,
      input  ready
   );

   modport sink (
      input  valid, row, span_from, span_to, fill_out, last_row,
      output ready
   );
endinterface

// ===== src/tssg_div.sv =====
// ----------------------------------------------------------------------------
// tssg_div
// Unsigned restoring divider, one quotient bit per cycle, sign carried along.
// ----------------------------------------------------------------------------
module tssg_div #(
   parameter int NUM_W = 29,
   parameter int DEN_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   input  logic             neg,
   output logic             done,
   output logic [NUM_W-1:0] quot,
   output logic             quot_neg
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] acc_ff, acc_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic             neg_ff, neg_in;
   logic             zero_ff, zero_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign shifted = {rem_ff, acc_ff[NUM_W-1]};
   assign trial   = shifted - {1'b0, den_ff};
   assign fits    = ~trial[DEN_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         acc_in  = num;
         rem_in  = '0;
         den_in  = den;
         neg_in  = neg;
         zero_in = (den == '0);
      end else if (busy_ff) begin
         acc_in = {acc_ff[NUM_W-2:0], fits};
         rem_in = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   assign done     = done_ff;
   assign quot     = zero_ff ? '0 : acc_ff;
   assign quot_neg = neg_ff;

endmodule

// ===== src/tssg_dp.sv =====
// ----------------------------------------------------------------------------
// tssg_dp
// Datapath: vertex sort, operand selection, divider, edge accumulators and
// the output word register.
// ----------------------------------------------------------------------------
module tssg_dp #(
   parameter int COORD_BITS = tssg_pkg::COORD_BITS_DEFAULT,
   parameter int FRAC_BITS  = tssg_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [COORD_BITS-1:0]       vert_a_x,
   input  logic signed [COORD_BITS-1:0]       vert_a_y,
   input  logic signed [COORD_BITS-1:0]       vert_b_x,
   input  logic signed [COORD_BITS-1:0]       vert_b_y,
   input  logic signed [COORD_BITS-1:0]       vert_c_x,
   input  logic signed [COORD_BITS-1:0]       vert_c_y,
   input  logic        [tssg_pkg::FILL_W-1:0] fill_value,
   input  tssg_pkg::dp_cmd_type               cmd,
   output tssg_pkg::dp_sts_type               sts,
   output logic signed [COORD_BITS-1:0]       row,
   output logic signed [COORD_BITS:0]         span_from,
   output logic signed [COORD_BITS:0]         span_to,
   output logic        [tssg_pkg::FILL_W-1:0] fill_out,
   output logic                               last_row
);

   localparam int DIFF_W = COORD_BITS + 1;
   localparam int NUM_W  = (DIFF_W + FRAC_BITS > 2 * DIFF_W) ?
                           (DIFF_W + FRAC_BITS) : (2 * DIFF_W);
   localparam int QX_W   = (NUM_W > 33) ? NUM_W : 33;
   localparam int POS_W  = tssg_pkg::POS_W;

   function automatic logic signed [DIFF_W-1:0] trunc_pos(input logic [POS_W-1:0] p);
      logic signed [POS_W-1:0] sh;
      logic                    corr;
      sh   = $signed(p) >>> FRAC_BITS;
      corr = p[POS_W-1] & (|p[FRAC_BITS-1:0]);
      return DIFF_W'(sh + POS_W'(corr));
   endfunction

   logic signed [COORD_BITS-1:0] srt_x [3];
   logic signed [COORD_BITS-1:0] srt_y [3];
   logic signed [COORD_BITS-1:0] tmp_x, tmp_y;

   logic signed [COORD_BITS-1:0] vx_ff [3];
   logic signed [COORD_BITS-1:0] vy_ff [3];
   logic [tssg_pkg::FILL_W-1:0]  fill_ff;
   logic signed [DIFF_W-1:0]     split_ff;
   logic [POS_W-1:0]             slope_ff [2];
   logic [POS_W-1:0]             pos_ff [2];
   logic signed [COORD_BITS-1:0] row_ff;
   tssg_pkg::phase_type          phase_ff, phase_in;

   logic signed [COORD_BITS-1:0] rsp_row_ff;
   logic signed [DIFF_W-1:0]     rsp_from_ff;
   logic signed [DIFF_W-1:0]     rsp_to_ff;
   logic [tssg_pkg::FILL_W-1:0]  rsp_fill_ff;
   logic                         rsp_last_ff;

   logic signed [DIFF_W-1:0] x0e, x1e, x2e, y0e, y1e, y2e;
   logic signed [DIFF_W-1:0] dx_sel, dy_sel;
   logic [DIFF_W-1:0]        dx_mag, dy_mul;
   logic [2*DIFF_W-1:0]      prod;
   logic [NUM_W-1:0]         div_num;
   logic                     div_done;
   logic [NUM_W-1:0]         div_q;
   logic                     div_q_neg;
   logic [QX_W-1:0]          q_ext;
   logic [POS_W-1:0]         slope_val;
   logic signed [DIFF_W-1:0] q_low, split_div, split_val;
   logic                     last_val;

   always_comb begin
      tmp_x    = '0;
      tmp_y    = '0;
      srt_x[0] = vert_a_x;
      srt_y[0] = vert_a_y;
      srt_x[1] = vert_b_x;
      srt_y[1] = vert_b_y;
      srt_x[2] = vert_c_x;
      srt_y[2] = vert_c_y;
      if (srt_y[0] > srt_y[1]) begin
         tmp_x = srt_x[0]; srt_x[0] = srt_x[1]; srt_x[1] = tmp_x;
         tmp_y = srt_y[0]; srt_y[0] = srt_y[1]; srt_y[1] = tmp_y;
      end
      if (srt_y[1] > srt_y[2]) begin
         tmp_x = srt_x[1]; srt_x[1] = srt_x[2]; srt_x[2] = tmp_x;
         tmp_y = srt_y[1]; srt_y[1] = srt_y[2]; srt_y[2] = tmp_y;
      end
      if (srt_y[0] > srt_y[1]) begin
         tmp_x = srt_x[0]; srt_x[0] = srt_x[1]; srt_x[1] = tmp_x;
         tmp_y = srt_y[0]; srt_y[0] = srt_y[1]; srt_y[1] = tmp_y;
      end
   end

   assign x0e = DIFF_W'(vx_ff[0]);
   assign x1e = DIFF_W'(vx_ff[1]);
   assign x2e = DIFF_W'(vx_ff[2]);
   assign y0e = DIFF_W'(vy_ff[0]);
   assign y1e = DIFF_W'(vy_ff[1]);
   assign y2e = DIFF_W'(vy_ff[2]);

   always_comb begin
      case (cmd.div_sel)
         tssg_pkg::DIV_SPLIT: begin
            dx_sel = x2e - x0e;
            dy_sel = y2e - y0e;
         end
         tssg_pkg::DIV_UP0: begin
            dx_sel = x1e - x0e;
            dy_sel = y1e - y0e;
         end
         tssg_pkg::DIV_UP1: begin
            dx_sel = split_ff - x0e;
            dy_sel = y1e - y0e;
         end
         tssg_pkg::DIV_LO0: begin
            dx_sel = x2e - x1e;
            dy_sel = y2e - y1e;
         end
         tssg_pkg::DIV_LO1: begin
            dx_sel = x2e - split_ff;
            dy_sel = y2e - y1e;
         end
         tssg_pkg::DIV_FT0: begin
            dx_sel = x2e - x0e;
            dy_sel = y2e - y0e;
         end
         tssg_pkg::DIV_FT1: begin
            dx_sel = x2e - x1e;
            dy_sel = y2e - y1e;
         end
         default: begin
            dx_sel = '0;
            dy_sel = '0;
         end
      endcase
   end

   assign dx_mag  = dx_sel[DIFF_W-1] ? $unsigned(-dx_sel) : $unsigned(dx_sel);
   assign dy_mul  = $unsigned(y1e - y0e);
   assign prod    = dx_mag * dy_mul;
   assign div_num = (cmd.div_sel == tssg_pkg::DIV_SPLIT) ? NUM_W'(prod) :
                    NUM_W'({dx_mag, {FRAC_BITS{1'b0}}});

   tssg_div #(
      .NUM_W (NUM_W),
      .DEN_W (DIFF_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (div_num),
      .den      ($unsigned(dy_sel)),
      .neg      (dx_sel[DIFF_W-1]),
      .done     (div_done),
      .quot     (div_q),
      .quot_neg (div_q_neg)
   );

   assign q_ext = QX_W'(div_q);

   always_comb begin
      if (!div_q_neg) begin
         slope_val = (q_ext > QX_W'(tssg_pkg::SLOPE_MAX)) ? tssg_pkg::SLOPE_MAX :
                     q_ext[POS_W-1:0];
      end else begin
         slope_val = (q_ext > QX_W'(tssg_pkg::SLOPE_MIN)) ? tssg_pkg::SLOPE_MIN :
                     (POS_W'(0) - q_ext[POS_W-1:0]);
      end
   end

   assign q_low     = $signed(div_q[DIFF_W-1:0]);
   assign split_div = (div_q_neg ? -q_low : q_low) + x0e;

   always_comb begin
      case (cmd.split_sel)
         tssg_pkg::SPLIT_X2:  split_val = x2e;
         tssg_pkg::SPLIT_X0:  split_val = x0e;
         tssg_pkg::SPLIT_DIV: split_val = split_div;
         default:             split_val = split_ff;
      endcase
   end

   assign last_val = (phase_ff == tssg_pkg::PH_UPPER) ?
                     ((row_ff == vy_ff[1]) && (vy_ff[1] == vy_ff[2])) :
                     (row_ff == vy_ff[1]);

   always_comb begin
      phase_in = phase_ff;
      if (cmd.init_upper) begin
         phase_in = tssg_pkg::PH_UPPER;
      end else if (cmd.init_lower) begin
         phase_in = tssg_pkg::PH_LOWER;
      end else if (cmd.go_idle) begin
         phase_in = tssg_pkg::PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tssg_pkg::PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      if (cmd.load) begin
         for (int i = 0; i < 3; i++) begin
            vx_ff[i] <= srt_x[i];
            vy_ff[i] <= srt_y[i];
         end
         fill_ff <= fill_value;
      end
      if (cmd.split_wr) begin
         split_ff <= split_val;
      end
      if (cmd.slope_wr) begin
         slope_ff[cmd.slope_idx] <= slope_val;
      end
      if (cmd.init_upper) begin
         pos_ff[0] <= POS_W'(vx_ff[0]) << FRAC_BITS;
         pos_ff[1] <= POS_W'(vx_ff[0]) << FRAC_BITS;
         row_ff    <= vy_ff[0];
      end else if (cmd.init_lower) begin
         pos_ff[0] <= POS_W'(vx_ff[2]) << FRAC_BITS;
         pos_ff[1] <= POS_W'(vx_ff[2]) << FRAC_BITS;
         row_ff    <= vy_ff[2];
      end else if (cmd.step_up) begin
         pos_ff[0] <= pos_ff[0] + slope_ff[0];
         pos_ff[1] <= pos_ff[1] + slope_ff[1];
         row_ff    <= row_ff + COORD_BITS'(1);
      end else if (cmd.step_down) begin
         pos_ff[0] <= pos_ff[0] - slope_ff[0];
         pos_ff[1] <= pos_ff[1] - slope_ff[1];
         row_ff    <= row_ff - COORD_BITS'(1);
      end
      if (cmd.emit) begin
         rsp_row_ff  <= row_ff;
         rsp_from_ff <= trunc_pos(pos_ff[0]);
         rsp_to_ff   <= trunc_pos(pos_ff[1]);
         rsp_fill_ff <= fill_ff;
         rsp_last_ff <= last_val;
      end
   end

   assign sts.phase     = phase_ff;
   assign sts.row_at_y1 = (row_ff == vy_ff[1]);
   assign sts.y0_eq_y1  = (vy_ff[0] == vy_ff[1]);
   assign sts.y1_eq_y2  = (vy_ff[1] == vy_ff[2]);
   assign sts.div_done  = div_done;

   assign row       = rsp_row_ff;
   assign span_from = rsp_from_ff;
   assign span_to   = rsp_to_ff;
   assign fill_out  = rsp_fill_ff;
   assign last_row  = rsp_last_ff;

endmodule

// ===== src/tssg_ctrl.sv =====
// ----------------------------------------------------------------------------
// tssg_ctrl
// Controller: sequences triangle set-up divisions and span steps, and owns
// the output word valid flag.
// ----------------------------------------------------------------------------
module tssg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_command,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tssg_pkg::dp_sts_type sts,
   output tssg_pkg::dp_cmd_type cmd
);

   tssg_pkg::state_type state_ff, state_in;
   tssg_pkg::seg_type   seg_ff, seg_in;
   logic                out_valid_ff, out_valid_in;
   logic                accept;
   logic                out_free;
   logic                active;

   assign accept   = req_valid & (state_ff == tssg_pkg::ST_IDLE);
   assign out_free = ~out_valid_ff | rsp_ready;
   assign active   = (sts.phase == tssg_pkg::PH_UPPER) || (sts.phase == tssg_pkg::PH_LOWER);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tssg_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_command == tssg_pkg::CMD_LOAD) ? tssg_pkg::ST_SETUP :
                          tssg_pkg::ST_SPAN;
            end
         end
         tssg_pkg::ST_SETUP: begin
            if (sts.y1_eq_y2 || sts.y0_eq_y1) begin
               state_in = tssg_pkg::ST_SLOPE0;
            end else begin
               state_in = tssg_pkg::ST_SPLIT;
            end
         end
         tssg_pkg::ST_SPLIT: begin
            if (sts.div_done) begin
               state_in = tssg_pkg::ST_SLOPE0;
            end
         end
         tssg_pkg::ST_SLOPE0: begin
            if (sts.div_done) begin
               state_in = tssg_pkg::ST_SLOPE1;
            end
         end
         tssg_pkg::ST_SLOPE1: begin
            if (sts.div_done) begin
               state_in = tssg_pkg::ST_IDLE;
            end
         end
         tssg_pkg::ST_SPAN: begin
            if (!active) begin
               state_in = tssg_pkg::ST_IDLE;
            end else if (out_free) begin
               if ((sts.phase == tssg_pkg::PH_UPPER) && sts.row_at_y1 && !sts.y1_eq_y2) begin
                  state_in = tssg_pkg::ST_SLOPE0;
               end else begin
                  state_in = tssg_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = tssg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.div_sel  = tssg_pkg::DIV_SPLIT;
      cmd.split_sel = tssg_pkg::SPLIT_DIV;
      seg_in       = seg_ff;
      req_ready    = (state_ff == tssg_pkg::ST_IDLE);
      case (state_ff)
         tssg_pkg::ST_IDLE: begin
            cmd.load = accept && (req_command == tssg_pkg::CMD_LOAD);
         end
         tssg_pkg::ST_SETUP: begin
            cmd.div_start = 1'b1;
            if (sts.y1_eq_y2) begin
               cmd.split_wr  = 1'b1;
               cmd.split_sel = tssg_pkg::SPLIT_X2;
               cmd.div_sel   = tssg_pkg::DIV_UP0;
               seg_in        = tssg_pkg::SEG_UPPER;
            end else if (sts.y0_eq_y1) begin
               cmd.split_wr  = 1'b1;
               cmd.split_sel = tssg_pkg::SPLIT_X0;
               cmd.div_sel   = tssg_pkg::DIV_FT0;
               seg_in        = tssg_pkg::SEG_FLAT_TOP;
            end else begin
               cmd.div_sel   = tssg_pkg::DIV_SPLIT;
               seg_in        = tssg_pkg::SEG_UPPER;
            end
         end
         tssg_pkg::ST_SPLIT: begin
            if (sts.div_done) begin
               cmd.split_wr  = 1'b1;
               cmd.split_sel = tssg_pkg::SPLIT_DIV;
               cmd.div_start = 1'b1;
               cmd.div_sel   = tssg_pkg::DIV_UP0;
            end
         end
         tssg_pkg::ST_SLOPE0: begin
            if (sts.div_done) begin
               cmd.slope_wr  = 1'b1;
               cmd.slope_idx = 1'b0;
               cmd.div_start = 1'b1;
               case (seg_ff)
                  tssg_pkg::SEG_UPPER:    cmd.div_sel = tssg_pkg::DIV_UP1;
                  tssg_pkg::SEG_LOWER:    cmd.div_sel = tssg_pkg::DIV_LO1;
                  tssg_pkg::SEG_FLAT_TOP: cmd.div_sel = tssg_pkg::DIV_FT1;
                  default:                cmd.div_sel = tssg_pkg::DIV_UP1;
               endcase
            end
         end
         tssg_pkg::ST_SLOPE1: begin
            if (sts.div_done) begin
               cmd.slope_wr   = 1'b1;
               cmd.slope_idx  = 1'b1;
               cmd.init_upper = (seg_ff == tssg_pkg::SEG_UPPER);
               cmd.init_lower = (seg_ff != tssg_pkg::SEG_UPPER);
            end
         end
         tssg_pkg::ST_SPAN: begin
            if (active && out_free) begin
               cmd.emit = 1'b1;
               if (sts.phase == tssg_pkg::PH_UPPER) begin
                  if (!sts.row_at_y1) begin
                     cmd.step_up = 1'b1;
                  end else if (sts.y1_eq_y2) begin
                     cmd.go_idle = 1'b1;
                  end else begin
                     cmd.div_start = 1'b1;
                     cmd.div_sel   = tssg_pkg::DIV_LO0;
                     seg_in        = tssg_pkg::SEG_LOWER;
                  end
               end else begin
                  cmd.go_idle   = sts.row_at_y1;
                  cmd.step_down = ~sts.row_at_y1;
               end
            end
         end
         default: begin
            cmd.load = 1'b0;
         end
      endcase
      out_valid_in = cmd.emit | (out_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tssg_pkg::ST_IDLE;
         seg_ff       <= tssg_pkg::SEG_UPPER;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_ff       <= seg_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ===== src/triangle_scanline_span_generator_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_scanline_span_generator_unit
// Flat-top / flat-bottom triangle fill: one horizontal span per request.
// ----------------------------------------------------------------------------
// A load word latches three vertices and a fill value, sorts them by y and
// works out the split x and both edge slopes on one shared divider that
// yields one quotient bit per cycle (N = max(COORD_BITS+1+FRAC_BITS,
// 2*COORD_BITS+2) bits, 29 with the default widths). In the general case a
// load runs the split division and then both slope divisions, and only the
// two slope divisions when one edge is flat; no word is accepted meanwhile.
// A span request is held until the output register is free, and the span
// ending the upper half also runs the two lower-half slope divisions.
// A finished span waits in the output register, and the block goes on taking
// words while it waits. A span request with no active triangle gives no word.
// ----------------------------------------------------------------------------
module triangle_scanline_span_generator_unit #(
   parameter int COORD_BITS = tssg_pkg::COORD_BITS_DEFAULT,
   parameter int FRAC_BITS  = tssg_pkg::FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   tssg_req_if.sink   req_chan,
   tssg_rsp_if.source rsp_chan
);

   tssg_pkg::dp_cmd_type cmd;
   tssg_pkg::dp_sts_type sts;

   tssg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   tssg_dp #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .vert_a_x   (req_chan.vert_a_x),
      .vert_a_y   (req_chan.vert_a_y),
      .vert_b_x   (req_chan.vert_b_x),
      .vert_b_y   (req_chan.vert_b_y),
      .vert_c_x   (req_chan.vert_c_x),
      .vert_c_y   (req_chan.vert_c_y),
      .fill_value (req_chan.fill_value),
      .cmd        (cmd),
      .sts        (sts),
      .row        (rsp_chan.row),
      .span_from  (rsp_chan.span_from),
      .span_to    (rsp_chan.span_to),
      .fill_out   (rsp_chan.fill_out),
      .last_row   (rsp_chan.last_row)
   );

`ifndef SYNTHESIS
   a_load_blocks : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && (req_chan.command == tssg_pkg::CMD_LOAD))
      |=> !req_chan.ready)
      else $error("request accepted during triangle set-up");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("output word overwritten before it was taken");

   a_emit_active : assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (sts.phase != tssg_pkg::PH_IDLE))
      else $error("span emitted with no active triangle");

   a_emit_valid : assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_chan.valid)
      else $error("emitted span not presented on the output");
`endif

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the triangle scanline span generator.
// ----------------------------------------------------------------------------
// Load words and span requests are queued up front and driven in random
// bursts. Every accepted word also runs through a scanline fill model kept
// in this bench, and the spans it yields are compared with the words that
// leave the block. The run opens with hand-picked triangles: flat top, flat
// bottom, a single row, extreme coordinates and a reload mid-triangle. Most
// of the random triangles are short, each followed by enough span requests
// to walk it through, and a few are cut short or are stray requests.
// ----------------------------------------------------------------------------
module testbench;

   localparam int COORD_BITS = tssg_pkg::COORD_BITS_DEFAULT;
   localparam int FRAC_BITS  = tssg_pkg::FRAC_BITS_DEFAULT;
   localparam int RANDOM_WORDS = 2000;

   typedef struct {
      logic                           command;
      logic signed [COORD_BITS-1:0]   ax, ay, bx, by, cx, cy;
      logic [tssg_pkg::FILL_W-1:0]    fill;
      bit                             drain;
   } req_word_type;

   typedef struct {
      logic signed [COORD_BITS-1:0]   row;
      logic signed [COORD_BITS:0]     from_x;
      logic signed [COORD_BITS:0]     to_x;
      logic [tssg_pkg::FILL_W-1:0]    fill;
      logic                           last;
   } span_type;

   typedef enum {RDY_ALWAYS, RDY_COIN, RDY_PATTERN, RDY_TRICKLE} stall_mode_type;

   logic clock;
   logic reset;

   tssg_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
   tssg_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_bus ();

   triangle_scanline_span_generator_unit #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   req_word_type        pending_words[$];
   span_type            expected_spans[$];
   req_word_type        on_bus;
   bit                  req_taken;
   int                  burst_left;
   int                  gap_left;
   stall_mode_type      stall_mode;
   int                  stall_left;
   int                  mismatches;

   // Fill model state.
   int                  corner_x[3];
   int                  corner_y[3];
   int                  split_col;
   logic [31:0]         edge_step[2];
   logic [31:0]         edge_acc[2];
   int                  scan_row;
   tssg_pkg::phase_type walk;
   logic [31:0]         span_fill;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [31:0] edge_slope(int dx, int dy);
      longint q;
      if (dy == 0) return '0;
      q = (longint'(dx) <<< FRAC_BITS) / longint'(dy);
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
   endfunction

   function automatic logic [31:0] fixed_of(int x);
      longint p;
      p = longint'(x) <<< FRAC_BITS;
      return p[31:0];
   endfunction

   function automatic logic signed [COORD_BITS:0] edge_x(logic [31:0] p);
      longint v;
      longint r;
      v = longint'($signed(p));
      r = (v >= 0) ? (v >>> FRAC_BITS) : -((-v) >>> FRAC_BITS);
      return r[COORD_BITS:0];
   endfunction

   function automatic void order_corners(int i, int j);
      int t;
      if (corner_y[i] > corner_y[j]) begin
         t = corner_x[i]; corner_x[i] = corner_x[j]; corner_x[j] = t;
         t = corner_y[i]; corner_y[i] = corner_y[j]; corner_y[j] = t;
      end
   endfunction

   function automatic void latch_triangle(req_word_type w);
      int x0, y0, x1, y1, x2, y2;
      corner_x[0] = int'(w.ax); corner_y[0] = int'(w.ay);
      corner_x[1] = int'(w.bx); corner_y[1] = int'(w.by);
      corner_x[2] = int'(w.cx); corner_y[2] = int'(w.cy);
      span_fill = w.fill;
      order_corners(0, 1);
      order_corners(1, 2);
      order_corners(0, 1);
      x0 = corner_x[0]; y0 = corner_y[0];
      x1 = corner_x[1]; y1 = corner_y[1];
      x2 = corner_x[2]; y2 = corner_y[2];
      if (y1 != y2 && y0 == y1) begin
         split_col = x0;
         edge_step[0] = edge_slope(x2 - x0, y2 - y0);
         edge_step[1] = edge_slope(x2 - x1, y2 - y1);
         edge_acc[0] = fixed_of(x2);
         edge_acc[1] = fixed_of(x2);
         scan_row = y2;
         walk = tssg_pkg::PH_LOWER;
      end else begin
         if (y1 == y2)
            split_col = x2;
         else
            split_col = int'((longint'(x2 - x0) * longint'(y1 - y0)) / longint'(y2 - y0)) + x0;
         edge_step[0] = edge_slope(x1 - x0, y1 - y0);
         edge_step[1] = edge_slope(split_col - x0, y1 - y0);
         edge_acc[0] = fixed_of(x0);
         edge_acc[1] = fixed_of(x0);
         scan_row = y0;
         walk = tssg_pkg::PH_UPPER;
      end
   endfunction

   function automatic void step_rasteriser(req_word_type w);
      span_type s;
      int       y1;
      int       y2;
      y1 = corner_y[1];
      y2 = corner_y[2];
      if (w.command == tssg_pkg::CMD_LOAD) begin
         latch_triangle(w);
         return;
      end
      if (walk == tssg_pkg::PH_IDLE) return;
      s.row    = scan_row[COORD_BITS-1:0];
      s.from_x = edge_x(edge_acc[0]);
      s.to_x   = edge_x(edge_acc[1]);
      s.fill   = span_fill;
      s.last   = (walk == tssg_pkg::PH_UPPER) ? (scan_row == y1 && y1 == y2) :
                 (scan_row == y1);
      expected_spans.push_back(s);
      if (walk == tssg_pkg::PH_UPPER) begin
         if (scan_row == y1) begin
            if (y1 == y2) begin
               walk = tssg_pkg::PH_IDLE;
            end else begin
               edge_step[0] = edge_slope(corner_x[2] - corner_x[1], y2 - y1);
               edge_step[1] = edge_slope(corner_x[2] - split_col, y2 - y1);
               edge_acc[0] = fixed_of(corner_x[2]);
               edge_acc[1] = fixed_of(corner_x[2]);
               scan_row = y2;
               walk = tssg_pkg::PH_LOWER;
            end
         end else begin
            scan_row++;
            edge_acc[0] = edge_acc[0] + edge_step[0];
            edge_acc[1] = edge_acc[1] + edge_step[1];
         end
      end else if (s.last) begin
         walk = tssg_pkg::PH_IDLE;
      end else begin
         scan_row--;
         edge_acc[0] = edge_acc[0] - edge_step[0];
         edge_acc[1] = edge_acc[1] - edge_step[1];
      end
   endfunction

   // Acceptance and checking, both on the rising edge.
   always @(posedge clock) begin
      req_taken = !reset && req_bus.valid && req_bus.ready;
      if (req_taken) step_rasteriser(on_bus);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_spans.size() == 0) begin
            $error("span word with none expected: row %0d", rsp_bus.row);
            mismatches++;
         end else begin
            span_type e;
            e = expected_spans.pop_front();
            if (rsp_bus.row !== e.row) begin
               $error("row: expected %0d, got %0d", e.row, rsp_bus.row);
               mismatches++;
            end
            if (rsp_bus.span_from !== e.from_x) begin
               $error("span_from: expected %0d, got %0d", e.from_x, rsp_bus.span_from);
               mismatches++;
            end
            if (rsp_bus.span_to !== e.to_x) begin
               $error("span_to: expected %0d, got %0d", e.to_x, rsp_bus.span_to);
               mismatches++;
            end
            if (rsp_bus.fill_out !== e.fill) begin
               $error("fill_out: expected %h, got %h", e.fill, rsp_bus.fill_out);
               mismatches++;
            end
            if (rsp_bus.last_row !== e.last) begin
               $error("last_row: expected %0d, got %0d", e.last, rsp_bus.last_row);
               mismatches++;
            end
         end
      end
   end

   // Sender: bursts of words separated by random gaps.
   always @(negedge clock) begin
      if (!reset && (!req_bus.valid || req_taken)) begin
         if (gap_left != 0) begin
            gap_left = gap_left - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_words.size() == 0 ||
                      (pending_words[0].drain && expected_spans.size() != 0)) begin
            req_bus.valid <= 1'b0;
         end else begin
            on_bus = pending_words.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.command    <= on_bus.command;
            req_bus.vert_a_x   <= on_bus.ax;
            req_bus.vert_a_y   <= on_bus.ay;
            req_bus.vert_b_x   <= on_bus.bx;
            req_bus.vert_b_y   <= on_bus.by;
            req_bus.vert_c_x   <= on_bus.cx;
            req_bus.vert_c_y   <= on_bus.cy;
            req_bus.fill_value <= on_bus.fill;
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
   end

   // Receiver: the stall mode is redrawn at random from always ready, coin toss, pattern and trickle.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(64, 256);
      end else begin
         stall_left = stall_left - 1;
      end
      case (stall_mode)
         RDY_ALWAYS: begin
            rsp_bus.ready <= 1'b1;
         end
         RDY_COIN: begin
            rsp_bus.ready <= 1'($urandom_range(0, 1));
         end
         RDY_PATTERN: begin
            rsp_bus.ready <= (stall_left % 5) < 2;
         end
         default: begin
            rsp_bus.ready <= ($urandom_range(0, 15) == 0);
         end
      endcase
   end

   function automatic req_word_type load_word(int ax, int ay, int bx, int by,
                                              int cx, int cy, logic [31:0] fill);
      req_word_type w;
      w.command = tssg_pkg::CMD_LOAD;
      w.ax = COORD_BITS'(ax); w.ay = COORD_BITS'(ay);
      w.bx = COORD_BITS'(bx); w.by = COORD_BITS'(by);
      w.cx = COORD_BITS'(cx); w.cy = COORD_BITS'(cy);
      w.fill  = fill;
      w.drain = 1'b0;
      return w;
   endfunction

   function automatic int queue_spans(int n);
      req_word_type w;
      for (int i = 0; i < n; i++) begin
         w = load_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         w.command = tssg_pkg::CMD_SPAN;
         pending_words.push_back(w);
      end
      return n;
   endfunction

   function automatic int coord_near(int h);
      int base;
      base = $urandom_range(0, 4095 - h) - 2048;
      return base;
   endfunction

   initial begin
      int           n_random;
      int           kind;
      int           h;
      int           ybase;
      int           xbase;
      int           xs[3];
      int           ys[3];
      int           ymin;
      int           ymax;
      int           n_spans;
      bit           wide;
      req_word_type w;

      reset = 1'b1;
      mismatches = 0;
      req_taken = 1'b0;
      burst_left = 1;
      gap_left = 0;
      stall_mode = RDY_ALWAYS;
      stall_left = 0;
      req_bus.valid = 1'b0;
      req_bus.command = tssg_pkg::CMD_SPAN;
      req_bus.vert_a_x = '0;
      req_bus.vert_a_y = '0;
      req_bus.vert_b_x = '0;
      req_bus.vert_b_y = '0;
      req_bus.vert_c_x = '0;
      req_bus.vert_c_y = '0;
      req_bus.fill_value = '0;
      rsp_bus.ready = 1'b0;
      walk = tssg_pkg::PH_IDLE;
      span_fill = '0;
      scan_row = 0;
      split_col = 0;
      foreach (corner_x[i]) begin
         corner_x[i] = 0;
         corner_y[i] = 0;
      end
      foreach (edge_step[i]) begin
         edge_step[i] = '0;
         edge_acc[i] = '0;
      end

      // A span request before any triangle, then a general triangle that
      // needs two exchanges in the sort, walked one request past its end.
      void'(queue_spans(1));
      pending_words.push_back(load_word(2047, 4, -2048, 0, 5, 2, 32'hFFFF_FFFF));
      void'(queue_spans(7));
      // Flat bottom, flat top, and a single row on the highest line.
      pending_words.push_back(load_word(0, 0, -5, 3, 6, 3, 32'h0000_0000));
      void'(queue_spans(4));
      pending_words.push_back(load_word(-7, -10, 9, -10, 1, -8, 32'h5A5A_A5A5));
      void'(queue_spans(3));
      pending_words.push_back(load_word(-2048, 2047, 2047, 2047, 0, 2047, 32'h8000_0001));
      void'(queue_spans(1));
      // Full-height triangle, left unfinished so that the next load replaces it.
      pending_words.push_back(load_word(-2048, -2048, 2047, -2047, 0, 2047, 32'h1234_5678));
      void'(queue_spans(4));

      n_random = 0;
      while (n_random < RANDOM_WORDS) begin
         kind = $urandom_range(0, 15);
         if (kind == 0) begin
            n_random += queue_spans($urandom_range(1, 3));
         end else begin
            h     = (kind == 1) ? $urandom_range(13, 80) : $urandom_range(0, 12);
            ybase = coord_near(h);
            xbase = coord_near(40);
            wide  = 1'($urandom_range(0, 1));
            for (int i = 0; i < 3; i++) begin
               ys[i] = ybase + $urandom_range(0, h);
               xs[i] = wide ? coord_near(0) : xbase + $urandom_range(0, 40);
            end
            if (kind == 2) ys[1] = ys[0];
            if (kind == 3) ys[2] = ys[1];
            ymin = ys[0];
            ymax = ys[0];
            for (int i = 1; i < 3; i++) begin
               if (ys[i] < ymin) ymin = ys[i];
               if (ys[i] > ymax) ymax = ys[i];
            end
            w = load_word(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], $urandom);
            w.drain = (n_random == 0) || ($urandom_range(0, 199) == 0);
            pending_words.push_back(w);
            n_random++;
            n_spans = ymax - ymin + 2 + $urandom_range(0, 1);
            if (kind == 4) n_spans = $urandom_range(0, n_spans - 1);
            n_random += queue_spans(n_spans);
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_words.size() != 0 || req_bus.valid) @(posedge clock);
      while (expected_spans.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #(12 * 1_500_000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
